// ===== hw/rtl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg: shared definitions for the checked frame receiver
// Widths, head byte, role codes, config register indexes and reset values.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int ROLE_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] HEAD_BYTE = 8'hAA;

  // Role of an echoed byte within the frame.
  localparam logic [ROLE_W-1:0] ROLE_DROPPED  = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_HEAD     = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_DEST     = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_FUNCTION = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_LENGTH   = 3'd4;
  localparam logic [ROLE_W-1:0] ROLE_PAYLOAD  = 3'd5;
  localparam logic [ROLE_W-1:0] ROLE_SUM      = 3'd6;
  localparam logic [ROLE_W-1:0] ROLE_ADDON    = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_EMPTY      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT      = 2'd3;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST       = 8'd98;
  localparam logic [BYTE_W-1:0] BROADCAST_ADDRESS_RST = 8'd255;
  localparam logic              ACCEPT_EMPTY_RST      = 1'b1;
  localparam logic [BYTE_W-1:0] LENGTH_LIMIT_RST      = 8'd250;

endpackage

// ===== hw/rtl/cfr_stream_if.sv =====
// ----------------------------------------------------------------------------
// cfr_stream_if: valid/ready channels of the checked frame receiver
// One interface for received bytes and one for the annotated result words.
// ----------------------------------------------------------------------------
interface cfr_rx_if import cfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_res_if import cfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic [ROLE_W-1:0] byte_role;
  logic [BYTE_W-1:0] payload_index;
  logic [BYTE_W-1:0] frame_function;
  logic [BYTE_W-1:0] frame_dest;
  logic              frame_done;
  logic              frame_good;

  modport source (output valid, output byte_value, output byte_role,
                  output payload_index, output frame_function, output frame_dest,
                  output frame_done, output frame_good, input ready);
  modport sink   (input valid, input byte_value, input byte_role,
                  input payload_index, input frame_function, input frame_dest,
                  input frame_done, input frame_good, output ready);
endinterface

// ===== hw/rtl/checked_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// checked_frame_receiver_top: byte-serial frame parser with two checksums
// Tracks head, destination, function, length, payload, sum and sum-of-sums
// bytes and annotates every received byte with its role in the frame.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the rx channel, one word per byte. For every byte
// accepted, exactly one result word leaves on the res channel, carrying the
// byte, its role, its payload index, the destination and function of the
// frame under way, and on the last checksum byte the done and good flags.
// A byte that breaks the frame format comes out with role zero and the
// parser returns to hunting for a head byte; that byte is never taken as a
// new head itself.
// The result is registered: an accepted byte appears on res in the next
// cycle. Throughput is one byte per cycle while res is not stalled; the
// parser state update, a compare and two 8-bit adds, is done on acceptance.
// The result register sits between the channels, so rx stays ready while
// res is empty or is being taken in the same cycle. When the receiver stalls
// res, one word waits in the result register and rx is held off.
// The configuration port writes own_address, broadcast_address, accept_empty
// and length_limit; write it only while the parser is idle.
// Synchronous reset restores the configuration defaults, empties the result
// register and puts the parser back to hunting for a head byte.
// ----------------------------------------------------------------------------
module checked_frame_receiver_top import cfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  cfr_rx_if.sink               rx,
  cfr_res_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  // Parser phase codes.
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_DEST    = 3'd1;
  localparam logic [2:0] PH_FUNC    = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SUM     = 3'd5;
  localparam logic [2:0] PH_ADDON   = 3'd6;

  // Configuration registers.
  logic [BYTE_W-1:0] own_address;
  logic [BYTE_W-1:0] broadcast_address;
  logic              accept_empty;
  logic [BYTE_W-1:0] length_limit;

  // Parser state and its next values.
  logic [2:0]        phase, phase_next;
  logic [BYTE_W-1:0] bytes_left, bytes_left_next;
  logic [BYTE_W-1:0] payload_count, payload_count_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] sum_of_sums, sum_of_sums_next;
  logic              sum_matched, sum_matched_next;
  logic [BYTE_W-1:0] latched_function, latched_function_next;
  logic [BYTE_W-1:0] latched_dest, latched_dest_next;

  // Result of the byte being accepted.
  logic [ROLE_W-1:0] role_c;
  logic [BYTE_W-1:0] pidx_c;
  logic              done_c;
  logic              good_c;

  // Result register.
  logic              res_valid;
  logic [BYTE_W-1:0] res_value;
  logic [ROLE_W-1:0] res_role;
  logic [BYTE_W-1:0] res_pidx;
  logic [BYTE_W-1:0] res_function;
  logic [BYTE_W-1:0] res_dest;
  logic              res_done;
  logic              res_good;

  logic              rx_fire;
  logic [BYTE_W-1:0] b;

  assign b        = rx.rx_byte;
  assign rx.ready = !res_valid || res.ready;
  assign rx_fire  = rx.valid && rx.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= OWN_ADDRESS_RST;
      broadcast_address <= BROADCAST_ADDRESS_RST;
      accept_empty      <= ACCEPT_EMPTY_RST;
      length_limit      <= LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS:       own_address       <= cfg_data;
        CFG_BROADCAST_ADDRESS: broadcast_address <= cfg_data;
        CFG_ACCEPT_EMPTY:      accept_empty      <= cfg_data[0];
        CFG_LENGTH_LIMIT:      length_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame parser: the role of the current byte and the state it leaves.
  always_comb begin
    phase_next            = phase;
    bytes_left_next       = bytes_left;
    payload_count_next    = payload_count;
    running_sum_next      = running_sum;
    sum_of_sums_next      = sum_of_sums;
    sum_matched_next      = sum_matched;
    latched_function_next = latched_function;
    latched_dest_next     = latched_dest;
    role_c                = ROLE_DROPPED;
    pidx_c                = '0;
    done_c                = 1'b0;
    good_c                = 1'b0;

    unique case (phase)
      PH_HUNT: begin
        if (b == HEAD_BYTE) begin
          role_c                = ROLE_HEAD;
          phase_next            = PH_DEST;
          // Both sums restart with the head byte itself.
          running_sum_next      = b;
          sum_of_sums_next      = b;
          latched_function_next = '0;
          latched_dest_next     = '0;
          sum_matched_next      = 1'b0;
          bytes_left_next       = '0;
          payload_count_next    = '0;
        end
      end
      PH_DEST: begin
        if (b == own_address || b == broadcast_address) begin
          role_c            = ROLE_DEST;
          phase_next        = PH_FUNC;
          latched_dest_next = b;
          running_sum_next  = running_sum + b;
          sum_of_sums_next  = sum_of_sums + running_sum_next;
        end
      end
      PH_FUNC: begin
        role_c                = ROLE_FUNCTION;
        phase_next            = PH_LENGTH;
        latched_function_next = b;
        running_sum_next      = running_sum + b;
        sum_of_sums_next      = sum_of_sums + running_sum_next;
      end
      PH_LENGTH: begin
        if (b < length_limit && (b != '0 || accept_empty)) begin
          role_c             = ROLE_LENGTH;
          bytes_left_next    = b;
          payload_count_next = '0;
          // An empty payload goes straight to the sum byte.
          phase_next         = (b == '0) ? PH_SUM : PH_PAYLOAD;
          running_sum_next   = running_sum + b;
          sum_of_sums_next   = sum_of_sums + running_sum_next;
        end
      end
      PH_PAYLOAD: begin
        if (bytes_left != '0) begin
          role_c             = ROLE_PAYLOAD;
          pidx_c             = payload_count;
          payload_count_next = payload_count + 8'd1;
          bytes_left_next    = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_SUM;
          end
          running_sum_next   = running_sum + b;
          sum_of_sums_next   = sum_of_sums + running_sum_next;
        end
      end
      PH_SUM: begin
        role_c           = ROLE_SUM;
        sum_matched_next = (b == running_sum);
        phase_next       = PH_ADDON;
      end
      PH_ADDON: begin
        role_c     = ROLE_ADDON;
        done_c     = 1'b1;
        good_c     = sum_matched && (b == sum_of_sums);
        phase_next = PH_HUNT;
      end
      default: ;
    endcase

    // A dropped byte sends the parser back to hunting.
    if (role_c == ROLE_DROPPED) begin
      phase_next            = PH_HUNT;
      bytes_left_next       = '0;
      latched_function_next = '0;
      latched_dest_next     = '0;
    end
  end

  // Parser state advances on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      bytes_left       <= '0;
      payload_count    <= '0;
      running_sum      <= '0;
      sum_of_sums      <= '0;
      sum_matched      <= 1'b0;
      latched_function <= '0;
      latched_dest     <= '0;
    end else if (rx_fire) begin
      phase            <= phase_next;
      bytes_left       <= bytes_left_next;
      payload_count    <= payload_count_next;
      running_sum      <= running_sum_next;
      sum_of_sums      <= sum_of_sums_next;
      sum_matched      <= sum_matched_next;
      latched_function <= latched_function_next;
      latched_dest     <= latched_dest_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx.ready) begin
      res_valid <= rx.valid;
    end
  end

  // Result register payload, loaded with each accepted byte.
  always_ff @(posedge clk) begin
    if (rx_fire) begin
      res_value    <= b;
      res_role     <= role_c;
      res_pidx     <= pidx_c;
      res_function <= latched_function_next;
      res_dest     <= latched_dest_next;
      res_done     <= done_c;
      res_good     <= good_c;
    end
  end

  assign res.valid          = res_valid;
  assign res.byte_value     = res_value;
  assign res.byte_role      = res_role;
  assign res.payload_index  = res_pidx;
  assign res.frame_function = res_function;
  assign res.frame_dest     = res_dest;
  assign res.frame_done     = res_done;
  assign res.frame_good     = res_good;

  // Every accepted byte shows up as a result word at the next edge.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    rx_fire |=> res_valid)
    else $error("accepted byte produced no result word");

  // A head byte seen while hunting starts a frame.
  a_head_starts_frame: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && phase == PH_HUNT && b == HEAD_BYTE)
      |=> (phase == PH_DEST && res_role == ROLE_HEAD))
    else $error("head byte did not start a frame");

  // The payload phase always has bytes still to come.
  a_payload_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_left != '0))
    else $error("payload phase with no bytes left");

  // A frame ends only on a sum-of-sums byte and returns the parser to hunting.
  a_done_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && done_c) |=> (phase == PH_HUNT && res_role == ROLE_ADDON))
    else $error("frame done without returning to hunting");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the checked frame receiver
// Received bytes are sent in bursts against a stalling result receiver. Every
// result word is checked, field by field, against an in-bench frame parser
// or, in the directed table, against values typed in by hand.
// ----------------------------------------------------------------------------
module tb;
  import cfr_pkg::*;

  // One annotated result word, in the order of the result channel fields.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [ROLE_W-1:0] role;
    logic [BYTE_W-1:0] index;
    logic [BYTE_W-1:0] func;
    logic [BYTE_W-1:0] dest;
    logic              done;
    logic              good;
  } frame_word_t;

  // A row of the directed table. When typed is clear the expected word
  // comes from the parser model and the remaining fields are unused.
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    logic [ROLE_W-1:0] role;
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] func;
    logic [BYTE_W-1:0] dest;
    logic              done;
    logic              good;
  } stim_row_t;

  // One setting of the four configuration registers.
  typedef struct packed {
    logic [BYTE_W-1:0] own;
    logic [BYTE_W-1:0] bcast;
    logic              empty;
    logic [BYTE_W-1:0] limit;
  } link_setup_t;

  // Where the model parser stands within a frame.
  typedef enum logic [2:0] {
    HUNT, AT_DEST, AT_FUNCTION, AT_LENGTH, AT_PAYLOAD, AT_SUM, AT_ADDON
  } parse_phase_e;

  localparam int DIRECTED_N   = 29;
  localparam int SETUP_N      = 7;
  localparam int WORDS_PER_SETUP = 265;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 5000;

  // The directed table runs with the reset configuration: own address 0x62,
  // broadcast 0xFF, empty payloads accepted, length limit 250.
  localparam stim_row_t DIRECTED [0:DIRECTED_N-1] = '{
    // A stray byte while hunting is dropped with every field cleared.
    '{8'h00, 1'b1, ROLE_DROPPED,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    // Good frame to the own address with an empty payload.
    '{8'hAA, 1'b1, ROLE_HEAD,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{8'h62, 1'b1, ROLE_DEST,     8'h00, 8'h00, 8'h62, 1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_FUNCTION, 8'h00, 8'h00, 8'h62, 1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_LENGTH,   8'h00, 8'h00, 8'h62, 1'b0, 1'b0},
    '{8'h0C, 1'b0, ROLE_DROPPED,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{8'hCE, 1'b0, ROLE_DROPPED,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    // Broadcast frame with extreme bytes and a wrong sum.
    '{8'hAA, 1'b1, ROLE_HEAD,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_DEST,     8'h00, 8'h00, 8'hFF, 1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_FUNCTION, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0},
    '{8'h02, 1'b1, ROLE_LENGTH,   8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_PAYLOAD,  8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_PAYLOAD,  8'h01, 8'hFF, 8'hFF, 1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_SUM,      8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_ADDON,    8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0},
    // A head byte in the destination slot is dropped, not taken as a head.
    '{8'hAA, 1'b1, ROLE_HEAD,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{8'hAA, 1'b1, ROLE_DROPPED,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    // A length equal to the limit breaks the frame.
    '{8'hAA, 1'b1, ROLE_HEAD,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{8'h62, 1'b1, ROLE_DEST,     8'h00, 8'h00, 8'h62, 1'b0, 1'b0},
    '{8'h07, 1'b1, ROLE_FUNCTION, 8'h00, 8'h07, 8'h62, 1'b0, 1'b0},
    '{8'hFA, 1'b1, ROLE_DROPPED,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    // Right sum, wrong sum-of-sums.
    '{8'hAA, 1'b1, ROLE_HEAD,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{8'h62, 1'b1, ROLE_DEST,     8'h00, 8'h00, 8'h62, 1'b0, 1'b0},
    '{8'h07, 1'b1, ROLE_FUNCTION, 8'h00, 8'h07, 8'h62, 1'b0, 1'b0},
    '{8'h01, 1'b1, ROLE_LENGTH,   8'h00, 8'h07, 8'h62, 1'b0, 1'b0},
    '{8'h80, 1'b1, ROLE_PAYLOAD,  8'h00, 8'h07, 8'h62, 1'b0, 1'b0},
    '{8'h94, 1'b0, ROLE_DROPPED,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{8'h70, 1'b1, ROLE_ADDON,    8'h00, 8'h07, 8'h62, 1'b1, 1'b0},
    '{8'hFF, 1'b1, ROLE_DROPPED,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0}
  };

  // Register settings walked by the random part; the last one is drawn
  // at random when it comes up.
  localparam link_setup_t SETUPS [0:SETUP_N-2] = '{
    '{8'd98,  8'd255, 1'b1, 8'd250},
    '{8'd0,   8'd0,   1'b0, 8'd255},
    '{8'd255, 8'hAA,  1'b1, 8'd1},
    '{8'hAA,  8'd1,   1'b1, 8'd0},
    '{8'd17,  8'd200, 1'b0, 8'd5},
    '{8'hAA,  8'h55,  1'b0, 8'd128}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  cfr_rx_if  rx_ch ();
  cfr_res_if res_ch ();

  checked_frame_receiver_top dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Model copy of the configuration registers.
  logic [BYTE_W-1:0] own_addr_m   = OWN_ADDRESS_RST;
  logic [BYTE_W-1:0] bcast_addr_m = BROADCAST_ADDRESS_RST;
  logic              empty_ok_m   = ACCEPT_EMPTY_RST;
  logic [BYTE_W-1:0] len_limit_m  = LENGTH_LIMIT_RST;

  // Model copy of the parser state.
  parse_phase_e      phase_m   = HUNT;
  logic [BYTE_W-1:0] left_m    = '0;
  logic [BYTE_W-1:0] count_m   = '0;
  logic [BYTE_W-1:0] sum_m     = '0;
  logic [BYTE_W-1:0] sos_m     = '0;
  logic              sum_ok_m  = 1'b0;
  logic [BYTE_W-1:0] func_m    = '0;
  logic [BYTE_W-1:0] dest_m    = '0;

  frame_word_t pending_annotations[$];
  int          mismatch_count = 0;
  int          burst_left     = 0;
  int          setup_sent     = 0;
  bit          hold_req       = 1'b0;
  int          hold_left      = 0;
  int          stall_tick     = 0;
  int          stall_mode     = 0;
  int          idle_cycles    = 0;
  frame_word_t seen_word;
  frame_word_t want_word;

  // Both checks fold in every byte from the head through the payload: the
  // sum adds the byte, the sum-of-sums adds the sum just formed.
  function automatic void fold_checks(input logic [BYTE_W-1:0] b);
    sum_m = sum_m + b;
    sos_m = sos_m + sum_m;
  endfunction

  // Advance the model parser by one received byte and return the word the
  // block should emit for it.
  function automatic frame_word_t annotate_byte(input logic [BYTE_W-1:0] b);
    frame_word_t w;
    w       = '0;
    w.value = b;
    w.role  = ROLE_DROPPED;
    case (phase_m)
      HUNT: begin
        if (b == HEAD_BYTE) begin
          w.role   = ROLE_HEAD;
          phase_m  = AT_DEST;
          sum_m    = '0;
          sos_m    = '0;
          fold_checks(b);
          func_m   = '0;
          dest_m   = '0;
          sum_ok_m = 1'b0;
          left_m   = '0;
          count_m  = '0;
        end
      end
      AT_DEST: begin
        if (b == own_addr_m || b == bcast_addr_m) begin
          w.role  = ROLE_DEST;
          phase_m = AT_FUNCTION;
          dest_m  = b;
          fold_checks(b);
        end
      end
      AT_FUNCTION: begin
        w.role  = ROLE_FUNCTION;
        phase_m = AT_LENGTH;
        func_m  = b;
        fold_checks(b);
      end
      AT_LENGTH: begin
        if (b < len_limit_m && (b != 0 || empty_ok_m)) begin
          w.role  = ROLE_LENGTH;
          left_m  = b;
          count_m = '0;
          phase_m = (b == 0) ? AT_SUM : AT_PAYLOAD;
          fold_checks(b);
        end
      end
      AT_PAYLOAD: begin
        // With nothing left the byte falls through as dropped.
        if (left_m != 0) begin
          w.role  = ROLE_PAYLOAD;
          w.index = count_m;
          count_m = count_m + 8'd1;
          left_m  = left_m - 8'd1;
          if (left_m == 0) phase_m = AT_SUM;
          fold_checks(b);
        end
      end
      AT_SUM: begin
        w.role   = ROLE_SUM;
        sum_ok_m = (b == sum_m);
        phase_m  = AT_ADDON;
      end
      AT_ADDON: begin
        w.role  = ROLE_ADDON;
        w.done  = 1'b1;
        w.good  = sum_ok_m && (b == sos_m);
        phase_m = HUNT;
      end
      default: ;
    endcase
    if (w.role == ROLE_DROPPED) begin
      phase_m = HUNT;
      left_m  = '0;
      func_m  = '0;
      dest_m  = '0;
    end
    w.func = func_m;
    w.dest = dest_m;
    return w;
  endfunction

  // Offer one received byte and wait until the block takes it. The sender
  // works in bursts; at the end of a burst it may drop valid for a gap.
  // On acceptance the expected word is queued, either the typed one from
  // the directed table or the one the model parser works out.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                           input frame_word_t typed_word);
    frame_word_t w;
    int          gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 32);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    w = annotate_byte(b);
    pending_annotations.push_back(typed ? typed_word : w);
    setup_sent++;
  endtask

  // Build one frame for the current setting, mostly well formed, and send
  // it, possibly cut short and followed by a few noise bytes. Lengths stay
  // small except now and then, or once when big is asked for. A frame is
  // also cut where the byte budget of the current setting runs out.
  task automatic send_frame(input bit big);
    logic [BYTE_W-1:0] frame_q[$];
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] ss;
    int                pick;
    int                len;
    int                max_ok;
    int                keep;
    s      = '0;
    ss     = '0;
    max_ok = int'(len_limit_m) - 1;
    pick   = $urandom_range(0, 99);
    frame_q.push_back(HEAD_BYTE);
    frame_q.push_back(pick < 50 ? own_addr_m :
                      pick < 92 ? bcast_addr_m : 8'($urandom_range(0, 255)));
    frame_q.push_back(8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (big && max_ok >= 0) len = max_ok;
    else if (max_ok < 0 || pick < 8) len = $urandom_range(int'(len_limit_m), 255);
    else if (pick < 10) len = $urandom_range(0, max_ok);
    else len = $urandom_range(0, max_ok < 6 ? max_ok : 6);
    frame_q.push_back(8'(len));
    repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
    foreach (frame_q[i]) begin
      s  = s + frame_q[i];
      ss = ss + s;
    end
    frame_q.push_back($urandom_range(0, 9) == 0 ? s ^ 8'($urandom_range(1, 255)) : s);
    frame_q.push_back($urandom_range(0, 9) == 0 ? ss ^ 8'($urandom_range(1, 255)) : ss);
    keep = frame_q.size();
    if ($urandom_range(0, 19) == 0) keep = $urandom_range(1, keep - 1);
    for (int i = 0; i < keep && setup_sent < WORDS_PER_SETUP; i++)
      send_byte(frame_q[i], 1'b0, '0);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4))
        send_byte($urandom_range(0, 2) == 0 ? HEAD_BYTE : 8'($urandom_range(0, 255)),
                  1'b0, '0);
    end
  endtask

  // Stop offering, then wait until every expected word has come out. The
  // block always answers a byte, so the wait ends once each answer is taken.
  task automatic drain;
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_annotations.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles, then lower the enable.
  task automatic apply_setup(input link_setup_t st);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_ADDRESS;
    cfg_data  <= st.own;
    @(negedge clk);
    cfg_index <= CFG_BROADCAST_ADDRESS;
    cfg_data  <= st.bcast;
    @(negedge clk);
    cfg_index <= CFG_ACCEPT_EMPTY;
    cfg_data  <= {{(BYTE_W-1){1'b0}}, st.empty};
    @(negedge clk);
    cfg_index <= CFG_LENGTH_LIMIT;
    cfg_data  <= st.limit;
    @(negedge clk);
    cfg_we    <= 1'b0;
    own_addr_m   = st.own;
    bcast_addr_m = st.bcast;
    empty_ok_m   = st.empty;
    len_limit_m  = st.limit;
  endtask

  task automatic report_field(input string field, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    mismatch_count++;
  endtask

  // The result receiver switches at random among five stall patterns. A hold
  // request makes it refuse words for a long stretch, so the result
  // register fills and the block pushes back on the sender.
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 4);
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= 1'($urandom_range(0, 1));
        2:       res_ch.ready <= ($urandom_range(0, 6) != 0);
        3:       res_ch.ready <= (stall_tick % 4 == 0);
        default: res_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Every result word taken is compared with the oldest expected word.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen_word = '{res_ch.byte_value, res_ch.byte_role, res_ch.payload_index,
                    res_ch.frame_function, res_ch.frame_dest, res_ch.frame_done,
                    res_ch.frame_good};
      if (pending_annotations.size() == 0) begin
        $display("%0t: result word with nothing expected, got %p", $time, seen_word);
        mismatch_count++;
      end else begin
        want_word = pending_annotations.pop_front();
        if (seen_word.value !== want_word.value)
          report_field("byte_value", want_word.value, seen_word.value);
        if (seen_word.role !== want_word.role)
          report_field("byte_role", 8'(want_word.role), 8'(seen_word.role));
        if (seen_word.index !== want_word.index)
          report_field("payload_index", want_word.index, seen_word.index);
        if (seen_word.func !== want_word.func)
          report_field("frame_function", want_word.func, seen_word.func);
        if (seen_word.dest !== want_word.dest)
          report_field("frame_dest", want_word.dest, seen_word.dest);
        if (seen_word.done !== want_word.done)
          report_field("frame_done", 8'(want_word.done), 8'(seen_word.done));
        if (seen_word.good !== want_word.good)
          report_field("frame_good", 8'(want_word.good), 8'(seen_word.good));
      end
    end
  end

  // Watchdog: too many cycles in a row with no word moving on either
  // channel means the block has hung.
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("checked_frame_receiver_top test failed");
    $finish;
  end

  // Main sequence: reset, directed table, then random frames under each
  // register setting in turn, then drain and report. The result receiver
  // drives its ready from its own process, starting at the first falling
  // edge while reset is still held.
  initial begin
    link_setup_t st;
    frame_word_t typed_word;
    bit          big;
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_OWN_ADDRESS;
    cfg_data      = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The directed table relies on the reset values of the registers.
    for (int i = 0; i < DIRECTED_N; i++) begin
      typed_word = '{DIRECTED[i].rx, DIRECTED[i].role, DIRECTED[i].idx,
                     DIRECTED[i].func, DIRECTED[i].dest, DIRECTED[i].done,
                     DIRECTED[i].good};
      send_byte(DIRECTED[i].rx, DIRECTED[i].typed, typed_word);
    end

    for (int k = 0; k < SETUP_N; k++) begin
      drain();
      if (k < SETUP_N - 1) begin
        st = SETUPS[k];
      end else begin
        st.own   = 8'($urandom_range(0, 255));
        st.bcast = 8'($urandom_range(0, 255));
        st.empty = 1'($urandom_range(0, 1));
        st.limit = 8'($urandom_range(1, 255));
      end
      apply_setup(st);
      // Under the first setting the receiver holds off for a long stretch
      // while the sender keeps offering bytes.
      if (k == 0) hold_req = 1'b1;
      big        = (st.limit == 8'd255);
      setup_sent = 0;
      while (setup_sent < WORDS_PER_SETUP) begin
        send_frame(big);
        big = 1'b0;
      end
    end

    drain();
    if (mismatch_count == 0 && pending_annotations.size() == 0)
      $display("checked_frame_receiver_top test passed");
    else
      $display("checked_frame_receiver_top test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_stream_if.sv
hw/rtl/checked_frame_receiver_top.sv
dv/tb.sv
